// ===== rtl/rgbd_pkg.sv =====
// Shared types and constants for the RGB888 to 16-bit error-carry dither core.
package rgbd_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned WDATA_W = 8;

  // A channel value shifted by the largest position, plus headroom for a
  // three-term sum.
  localparam int unsigned SUM_W = CHAN_W + (2 ** POS_W - 1) + 2;

  localparam logic [CHAN_W-1:0] SAT_MAX = 8'd255;

  typedef enum logic [IDX_W-1:0] {
    REG_RED_MASK   = 3'd0,
    REG_GREEN_MASK = 3'd1,
    REG_BLUE_MASK  = 3'd2,
    REG_RED_POS    = 3'd3,
    REG_GREEN_POS  = 3'd4,
    REG_BLUE_POS   = 3'd5,
    REG_SHIFT      = 3'd6,
    REG_GRAY_MODE  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_keep;
    logic [CHAN_W-1:0] green_keep;
    logic [CHAN_W-1:0] blue_keep;
    logic [POS_W-1:0]  red_pos;
    logic [POS_W-1:0]  green_pos;
    logic [POS_W-1:0]  blue_pos;
    logic [POS_W-1:0]  shift;
    logic              gray;
  } cfg_t;

endpackage

// ===== rtl/rgbd_cfg.sv =====
// Configuration register file of the dither core.
module rgbd_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rgbd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rgbd_pkg::WDATA_W-1:0] cfg_wdata,
  output rgbd_pkg::cfg_t               cfg
);
  import rgbd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RED_MASK:   cfg_nxt.red_keep   = cfg_wdata[CHAN_W-1:0];
        REG_GREEN_MASK: cfg_nxt.green_keep = cfg_wdata[CHAN_W-1:0];
        REG_BLUE_MASK:  cfg_nxt.blue_keep  = cfg_wdata[CHAN_W-1:0];
        REG_RED_POS:    cfg_nxt.red_pos    = cfg_wdata[POS_W-1:0];
        REG_GREEN_POS:  cfg_nxt.green_pos  = cfg_wdata[POS_W-1:0];
        REG_BLUE_POS:   cfg_nxt.blue_pos   = cfg_wdata[POS_W-1:0];
        REG_SHIFT:      cfg_nxt.shift      = cfg_wdata[POS_W-1:0];
        REG_GRAY_MODE:  cfg_nxt.gray       = cfg_wdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red_keep   <= 8'hF8;
      cfg_r.green_keep <= 8'hFC;
      cfg_r.blue_keep  <= 8'hF8;
      cfg_r.red_pos    <= 5'd11;
      cfg_r.green_pos  <= 5'd6;
      cfg_r.blue_pos   <= 5'd0;
      cfg_r.shift      <= 5'd3;
      cfg_r.gray       <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/rgbd_chan.sv =====
// One channel's carry add with saturation and keep-mask selection.
module rgbd_chan (
  input  logic [rgbd_pkg::CHAN_W-1:0] carry,
  input  logic [rgbd_pkg::CHAN_W-1:0] mask,
  input  logic [rgbd_pkg::CHAN_W-1:0] pix,
  output logic [rgbd_pkg::CHAN_W-1:0] carry_nxt,
  output logic [rgbd_pkg::CHAN_W-1:0] kept
);
  import rgbd_pkg::*;

  logic [CHAN_W:0] sum;

  // The dropped bits of the previous value ride into the new byte.
  assign sum       = {1'b0, carry & ~mask} + {1'b0, pix};
  assign carry_nxt = sum[CHAN_W] ? SAT_MAX : sum[CHAN_W-1:0];
  assign kept      = carry_nxt & mask;

endmodule

// ===== rtl/rgbd_pack.sv =====
// Places the kept channel bits, sums them and applies the final right shift.
module rgbd_pack (
  input  logic [rgbd_pkg::CHAN_W-1:0] red_kept,
  input  logic [rgbd_pkg::CHAN_W-1:0] green_kept,
  input  logic [rgbd_pkg::CHAN_W-1:0] blue_kept,
  input  rgbd_pkg::cfg_t              cfg,
  output logic [rgbd_pkg::WORD_W-1:0] pixel_word
);
  import rgbd_pkg::*;

  logic [CHAN_W-1:0] g_val;
  logic [CHAN_W-1:0] b_val;
  logic [SUM_W-1:0]  r_sh;
  logic [SUM_W-1:0]  g_sh;
  logic [SUM_W-1:0]  b_sh;
  logic [SUM_W-1:0]  total;
  logic [SUM_W-1:0]  total_sh;

  // In mono mode the gray value lands at all three positions.
  assign g_val = cfg.gray ? red_kept : green_kept;
  assign b_val = cfg.gray ? red_kept : blue_kept;

  assign r_sh = {{(SUM_W-CHAN_W){1'b0}}, red_kept} << cfg.red_pos;
  assign g_sh = {{(SUM_W-CHAN_W){1'b0}}, g_val} << cfg.green_pos;
  assign b_sh = {{(SUM_W-CHAN_W){1'b0}}, b_val} << cfg.blue_pos;

  assign total      = r_sh + g_sh + b_sh;
  assign total_sh   = total >> cfg.shift;
  assign pixel_word = total_sh[WORD_W-1:0];

endmodule

// ===== rtl/rgb888_to_16bit_error_carry_dither_core.sv =====
// Top level of the RGB888 to 16-bit error-carry dither core.
//
// Input channel: in_valid/in_ready carry one pixel per transfer (red, green,
// blue bytes and a last-of-row flag). In mono mode the gray byte comes in
// in_red_in and the other two bytes are ignored. Output channel:
// out_valid/out_ready carry the packed 16-bit pixel and the row flag.
// Configuration: cfg_we writes cfg_wdata into the register at cfg_index in
// the same cycle; write only while no pixel is in flight.
//
// An input transfer loads the input register; when the pixel advances, the
// carry add, packing and final shift load the output register, which drives
// out_valid. Throughput is one pixel per cycle while the receiver does not
// stall. The carry registers form a loop, updated when a pixel moves from
// the input register into the output register (green and blue only outside
// mono mode), so pixel order defines the carry chain and the carry runs on
// across row ends.
// Reset (synchronous, active low) clears both pipeline valid bits and the
// carries and loads the RGB565 register defaults. When the receiver stalls,
// the output register holds its pixel and the input register can still take
// one more; in_ready drops only when both are full and out_ready is low.
module rgb888_to_16bit_error_carry_dither_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rgbd_pkg::CHAN_W-1:0]   in_red_in,
  input  logic [rgbd_pkg::CHAN_W-1:0]   in_green_in,
  input  logic [rgbd_pkg::CHAN_W-1:0]   in_blue_in,
  input  logic                          in_row_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rgbd_pkg::WORD_W-1:0]   out_pixel_word,
  output logic                          out_row_done,
  input  logic                          cfg_we,
  input  logic [rgbd_pkg::IDX_W-1:0]    cfg_index,
  input  logic [rgbd_pkg::WDATA_W-1:0]  cfg_wdata
);
  import rgbd_pkg::*;

  cfg_t cfg;

  // Input register.
  logic              s1_valid_r, s1_valid_nxt;
  logic [CHAN_W-1:0] s1_red_r, s1_green_r, s1_blue_r;
  logic              s1_row_r;

  // Carry state.
  logic [CHAN_W-1:0] red_carry_r, green_carry_r, blue_carry_r;
  logic [CHAN_W-1:0] red_carry_nxt, green_carry_nxt, blue_carry_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r;
  logic              out_row_r;

  logic              in_xfer;
  logic              adv;
  logic [CHAN_W-1:0] red_keep_eff;
  logic [CHAN_W-1:0] red_kept, green_kept, blue_kept;
  logic [WORD_W-1:0] word;

  rgbd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Mono mode keeps only the bits that all three masks keep.
  assign red_keep_eff = cfg.gray ? (cfg.red_keep & cfg.green_keep & cfg.blue_keep)
                                 : cfg.red_keep;

  rgbd_chan u_red (
    .carry     (red_carry_r),
    .mask      (red_keep_eff),
    .pix       (s1_red_r),
    .carry_nxt (red_carry_nxt),
    .kept      (red_kept)
  );

  rgbd_chan u_green (
    .carry     (green_carry_r),
    .mask      (cfg.green_keep),
    .pix       (s1_green_r),
    .carry_nxt (green_carry_nxt),
    .kept      (green_kept)
  );

  rgbd_chan u_blue (
    .carry     (blue_carry_r),
    .mask      (cfg.blue_keep),
    .pix       (s1_blue_r),
    .carry_nxt (blue_carry_nxt),
    .kept      (blue_kept)
  );

  rgbd_pack u_pack (
    .red_kept   (red_kept),
    .green_kept (green_kept),
    .blue_kept  (blue_kept),
    .cfg        (cfg),
    .pixel_word (word)
  );

  // A pixel advances when the output register is empty or being drained.
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      red_carry_r   <= '0;
      green_carry_r <= '0;
      blue_carry_r  <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        red_carry_r <= red_carry_nxt;
        // Green and blue carries hold their values in mono mode.
        if (!cfg.gray) begin
          green_carry_r <= green_carry_nxt;
          blue_carry_r  <= blue_carry_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_red_r   <= in_red_in;
      s1_green_r <= in_green_in;
      s1_blue_r  <= in_blue_in;
      s1_row_r   <= in_row_last;
    end
    if (adv) begin
      out_word_r <= word;
      out_row_r  <= s1_row_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_word = out_word_r;
  assign out_row_done   = out_row_r;

`ifndef SYNTH
  a_carry_reset: assert property (@(posedge clk)
    !rst_n |=> (red_carry_r == '0) && (green_carry_r == '0) && (blue_carry_r == '0))
    else $error("carries not cleared by reset");

  a_gray_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && cfg.gray) |=> $stable(green_carry_r) && $stable(blue_carry_r))
    else $error("green or blue carry changed in mono mode");

  a_carry_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(red_carry_r) && $stable(green_carry_r) && $stable(blue_carry_r))
    else $error("carry changed without a pixel advancing");

  a_adv_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid && (out_row_done == $past(s1_row_r)))
    else $error("advancing pixel did not reach the output register");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with an empty input register");
`endif

endmodule

// ===== verif/rgb888_to_16bit_error_carry_dither_core_test.sv =====
// Self-checking testbench for the RGB888 to 16-bit error-carry dither core.
module rgb888_to_16bit_error_carry_dither_core_test;
  import rgbd_pkg::*;

  // The run is about 1200 pixels plus the register writes. Even with both
  // sides stalling, it ends far short of this ceiling, so the ceiling only
  // catches a hang.
  localparam int CYCLE_LIMIT  = 400000;
  // Wait past the input and output registers to catch any stray output transfer.
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PCT     = 23;
  localparam int REPORT_MAX   = 10;
  localparam int NUM_REGS     = 8;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_PIXELS = 115;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              row_last;
  } pixel_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              row_done;
  } packed_px_t;

  // Raw bytes written to the registers, indexed by register index.
  typedef logic [NUM_REGS-1:0][WDATA_W-1:0] reg_bytes_t;

  logic                 clk;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [CHAN_W-1:0]    in_red_in      = '0;
  logic [CHAN_W-1:0]    in_green_in    = '0;
  logic [CHAN_W-1:0]    in_blue_in     = '0;
  logic                 in_row_last    = 1'b0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [WORD_W-1:0]    out_pixel_word;
  logic                 out_row_done;
  logic                 cfg_we         = 1'b0;
  logic [IDX_W-1:0]     cfg_index      = REG_RED_MASK;
  logic [WDATA_W-1:0]   cfg_wdata      = '0;

  // Pixels waiting for the driver, and packed words still owed by the block.
  pixel_t     pixel_backlog[$];
  packed_px_t words_due[$];

  // Our own copy of the register file and of the three error carries.
  cfg_t              dither_cfg;
  logic [CHAN_W-1:0] red_residue   = '0;
  logic [CHAN_W-1:0] green_residue = '0;
  logic [CHAN_W-1:0] blue_residue  = '0;

  // When set, neither side inserts bubbles, so the pipeline runs at full rate.
  bit          no_gaps    = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  int          row_left   = 0;

  rgb888_to_16bit_error_carry_dither_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .in_row_last    (in_row_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_word (out_pixel_word),
    .out_row_done   (out_row_done),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The dropped bits of the previous sum are added to the new byte, and the
  // result clips at full scale.
  function automatic logic [CHAN_W-1:0] saturating_sum(input logic [CHAN_W-1:0] residue,
                                                       input logic [CHAN_W-1:0] mask,
                                                       input logic [CHAN_W-1:0] pix);
    logic [CHAN_W:0] s;
    s = {1'b0, residue & ~mask} + {1'b0, pix};
    return (s > SAT_MAX) ? SAT_MAX : s[CHAN_W-1:0];
  endfunction

  // Computes the packed word for one pixel and advances the carries. The sum
  // is kept 64 bits wide so that positions up to 31 lose nothing before the
  // final shift.
  function automatic packed_px_t dither_pixel(input pixel_t px);
    logic [CHAN_W-1:0] mono_mask;
    logic [63:0]       red_part;
    logic [63:0]       green_part;
    logic [63:0]       blue_part;
    logic [63:0]       total;
    packed_px_t        res;
    if (dither_cfg.gray) begin
      // Mono: one shared mask, only the red carry moves, and the masked gray
      // value lands at all three positions.
      mono_mask   = dither_cfg.red_keep & dither_cfg.green_keep & dither_cfg.blue_keep;
      red_residue = saturating_sum(red_residue, mono_mask, px.red);
      red_part    = 64'(red_residue & mono_mask);
      total = (red_part << dither_cfg.red_pos) + (red_part << dither_cfg.green_pos)
            + (red_part << dither_cfg.blue_pos);
    end else begin
      red_residue   = saturating_sum(red_residue, dither_cfg.red_keep, px.red);
      green_residue = saturating_sum(green_residue, dither_cfg.green_keep, px.green);
      blue_residue  = saturating_sum(blue_residue, dither_cfg.blue_keep, px.blue);
      red_part   = 64'(red_residue & dither_cfg.red_keep);
      green_part = 64'(green_residue & dither_cfg.green_keep);
      blue_part  = 64'(blue_residue & dither_cfg.blue_keep);
      total = (red_part << dither_cfg.red_pos) + (green_part << dither_cfg.green_pos)
            + (blue_part << dither_cfg.blue_pos);
    end
    total        = total >> dither_cfg.shift;
    res.word     = total[WORD_W-1:0];
    res.row_done = px.row_last;
    return res;
  endfunction

  // Decodes raw register bytes the way the block does: the 5-bit registers
  // keep their low bits, the mode register keeps bit 0.
  function automatic void load_model(input reg_bytes_t raw);
    dither_cfg.red_keep   = raw[REG_RED_MASK];
    dither_cfg.green_keep = raw[REG_GREEN_MASK];
    dither_cfg.blue_keep  = raw[REG_BLUE_MASK];
    dither_cfg.red_pos    = raw[REG_RED_POS][POS_W-1:0];
    dither_cfg.green_pos  = raw[REG_GREEN_POS][POS_W-1:0];
    dither_cfg.blue_pos   = raw[REG_BLUE_POS][POS_W-1:0];
    dither_cfg.shift      = raw[REG_SHIFT][POS_W-1:0];
    dither_cfg.gray       = raw[REG_GRAY_MODE][0];
  endfunction

  function automatic reg_bytes_t rgb565_setting();
    reg_bytes_t s;
    s[REG_RED_MASK]   = 8'hF8;
    s[REG_GREEN_MASK] = 8'hFC;
    s[REG_BLUE_MASK]  = 8'hF8;
    s[REG_RED_POS]    = 8'd11;
    s[REG_GREEN_POS]  = 8'd6;
    s[REG_BLUE_POS]   = 8'd0;
    s[REG_SHIFT]      = 8'd3;
    s[REG_GRAY_MODE]  = 8'd0;
    return s;
  endfunction

  function automatic logic [WDATA_W-1:0] pick_mask();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'hF8;
      3: return 8'hFC;
      default: return WDATA_W'($urandom);
    endcase
  endfunction

  // Mostly within the documented range; now and then a full random byte,
  // which also exercises counts up to 31 and the ignored upper bits.
  function automatic logic [WDATA_W-1:0] pick_count(input int unsigned hi);
    if ($urandom_range(7) == 0)
      return WDATA_W'($urandom);
    return WDATA_W'($urandom_range(hi));
  endfunction

  function automatic logic [CHAN_W-1:0] pick_byte();
    case ($urandom_range(7))
      0: return '0;
      1: return SAT_MAX;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic void push_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                                     input logic [CHAN_W-1:0] b, input logic last);
    pixel_t px;
    px.red      = r;
    px.green    = g;
    px.blue     = b;
    px.row_last = last;
    pixel_backlog.push_back(px);
  endfunction

  // Random pixels cut into rows of random length, so row_last falls at
  // varying distances and the carry has to run across every row end.
  function automatic void push_random_pixels(input int count);
    for (int k = 0; k < count; k++) begin
      if (row_left == 0) begin
        row_left = $urandom_range(48, 1);
      end
      row_left--;
      push_pixel(pick_byte(), pick_byte(), pick_byte(), row_left == 0);
    end
  endfunction

  // Writes all eight registers on consecutive cycles. cfg_we rises once and
  // falls once, so no cycle carries two updates of it. The block is idle
  // here, so the model takes the new values right away.
  task automatic program_regs(input reg_bytes_t raw);
    for (int i = 0; i < NUM_REGS; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_wdata <= raw[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    load_model(raw);
  endtask

  // Waits until the driver has nothing left and every packed word has come
  // back, then lets the pipeline settle before touching the registers.
  task automatic drain();
    while (pixel_backlog.size() != 0 || in_valid || words_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic record_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("mismatch at cycle %0d: %s", cycles, what);
    end
  endtask

  // Driver. At each edge it first books the transfer that just happened,
  // predicting its packed word, then decides what the channel shows next.
  // A new pixel goes up only when the slot is free, so a pending pixel is
  // never changed or withdrawn before its transfer.
  always @(posedge clk) begin : drive_proc
    pixel_t nxt;
    if (rst_n && in_valid && in_ready) begin
      words_due.push_back(dither_pixel(pixel_t'({in_red_in, in_green_in, in_blue_in,
                                                  in_row_last})));
    end
    if (rst_n && (!in_valid || in_ready)) begin
      if (pixel_backlog.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = pixel_backlog.pop_front();
        in_valid    <= 1'b1;
        in_red_in   <= nxt.red;
        in_green_in <= nxt.green;
        in_blue_in  <= nxt.blue;
        in_row_last <= nxt.row_last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor. Every output transfer is matched against the oldest word owed;
  // out_ready drops at random to back the pipeline up.
  always @(posedge clk) begin : check_proc
    packed_px_t want;
    if (rst_n && out_valid && out_ready) begin
      if (words_due.size() == 0) begin
        record_mismatch($sformatf("unexpected transfer, word %h row_done %b",
                                  out_pixel_word, out_row_done));
      end else begin
        want = words_due.pop_front();
        if (out_pixel_word !== want.word || out_row_done !== want.row_done) begin
          record_mismatch($sformatf("word exp %h got %h, row_done exp %b got %b",
                                    want.word, out_pixel_word, want.row_done, out_row_done));
        end
      end
    end
    out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog against a stuck handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    reg_bytes_t setting;
    load_model(rgb565_setting());
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: plain RGB565 packing. Black, full-scale white twice so
    // the carry clips, a small value twice so the dropped bits build up
    // into a kept bit, and alternating bit patterns.
    push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    push_pixel(8'h07, 8'h03, 8'h07, 1'b0);
    push_pixel(8'h07, 8'h03, 8'h07, 1'b0);
    push_pixel(8'h01, 8'h01, 8'h01, 1'b1);
    push_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
    push_pixel(8'h55, 8'hAA, 8'h55, 1'b1);
    drain();

    // Switch to mono with the carries left over from color; green and blue
    // bytes carry junk that must be ignored.
    setting = rgb565_setting();
    setting[REG_GRAY_MODE] = 8'd1;
    program_regs(setting);
    push_pixel(8'h03, 8'hFF, 8'h00, 1'b0);
    push_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
    push_pixel(8'h05, 8'h00, 8'h00, 1'b0);
    push_pixel(8'h05, 8'h00, 8'h00, 1'b1);
    push_pixel(8'hFA, 8'hAA, 8'h55, 1'b0);
    drain();

    // Keep every bit, no final shift, red at the top of the range.
    setting[REG_RED_MASK]   = 8'hFF;
    setting[REG_GREEN_MASK] = 8'hFF;
    setting[REG_BLUE_MASK]  = 8'hFF;
    setting[REG_RED_POS]    = 8'd24;
    setting[REG_GREEN_POS]  = 8'd0;
    setting[REG_BLUE_POS]   = 8'd8;
    setting[REG_SHIFT]      = 8'd0;
    setting[REG_GRAY_MODE]  = 8'd0;
    program_regs(setting);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    push_pixel(8'h80, 8'h01, 8'hFE, 1'b0);
    push_pixel(8'h01, 8'h80, 8'h7F, 1'b1);
    drain();

    // Keep nothing: every byte goes into the carry and the word stays zero.
    setting[REG_RED_MASK]   = 8'h00;
    setting[REG_GREEN_MASK] = 8'h00;
    setting[REG_BLUE_MASK]  = 8'h00;
    setting[REG_RED_POS]    = 8'd0;
    setting[REG_BLUE_POS]   = 8'd0;
    setting[REG_SHIFT]      = 8'd16;
    program_regs(setting);
    push_pixel(8'hC8, 8'hC8, 8'hC8, 1'b0);
    push_pixel(8'h64, 8'h64, 8'h64, 1'b0);
    push_pixel(8'h01, 8'h02, 8'h03, 1'b1);
    drain();

    // Counts beyond the documented range and junk in the unused upper bits:
    // red and green at 31, blue at 1, shift 16, mono with a thin shared mask.
    setting[REG_RED_MASK]   = 8'hFF;
    setting[REG_GREEN_MASK] = 8'h7F;
    setting[REG_BLUE_MASK]  = 8'hFE;
    setting[REG_RED_POS]    = 8'hFF;
    setting[REG_GREEN_POS]  = 8'h3F;
    setting[REG_BLUE_POS]   = 8'hE1;
    setting[REG_SHIFT]      = 8'hF0;
    setting[REG_GRAY_MODE]  = 8'hFF;
    program_regs(setting);
    push_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    push_pixel(8'h00, 8'hFF, 8'hFF, 1'b1);
    push_pixel(8'h81, 8'h00, 8'h00, 1'b0);
    drain();

    // Everything at 31: the wide sum is shifted back down by the full count.
    setting[REG_GREEN_MASK] = 8'hFF;
    setting[REG_BLUE_MASK]  = 8'hFF;
    setting[REG_RED_POS]    = 8'h1F;
    setting[REG_GREEN_POS]  = 8'h1F;
    setting[REG_BLUE_POS]   = 8'h1F;
    setting[REG_SHIFT]      = 8'h1F;
    setting[REG_GRAY_MODE]  = 8'h00;
    program_regs(setting);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'h7F, 8'h01, 8'h80, 1'b1);
    drain();

    // Random phases. The first goes back to the RGB565 defaults, one runs
    // with no bubbles on either side, and the rest use random registers.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase == 0) begin
        setting = rgb565_setting();
      end else begin
        setting[REG_RED_MASK]   = pick_mask();
        setting[REG_GREEN_MASK] = pick_mask();
        setting[REG_BLUE_MASK]  = pick_mask();
        setting[REG_RED_POS]    = pick_count(24);
        setting[REG_GREEN_POS]  = pick_count(24);
        setting[REG_BLUE_POS]   = pick_count(24);
        setting[REG_SHIFT]      = pick_count(16);
        setting[REG_GRAY_MODE]  = {7'($urandom), $urandom_range(2) == 0};
      end
      program_regs(setting);
      no_gaps = (phase == 4);
      push_random_pixels(PHASE_PIXELS);
      drain();
      no_gaps = 1'b0;
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
